FILE: rtl/core/cfaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfaf_pkg
// Types, character codes and helpers shared by the CAN log text formatter.
// ----------------------------------------------------------------------------
package cfaf_pkg;

  // item kinds
  localparam logic ActHeader = 1'b0;
  localparam logic ActData   = 1'b1;

  // characters per job: one header yields at most twelve
  localparam int unsigned JobChars = 12;
  localparam int unsigned CountW   = 4;

  // job queue between front and back, power-of-two depth
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = 1;
  localparam int unsigned QCountW    = 2;

  localparam int unsigned RemainW = 7;

  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChR     = 8'h52;
  localparam logic [7:0] ChDot   = 8'h2E;

  localparam logic [7:0] ClassicMax = 8'd8;
  localparam logic [7:0] RawDlcLo   = 8'd9;
  localparam logic [7:0] RawDlcHi   = 8'd15;

  localparam logic [7:0] HexTable [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef struct packed {
    logic [JobChars-1:0][7:0] chars;
    logic [CountW-1:0]        count;
    logic                     eol;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    hex_char = HexTable[d];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cfaf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfaf_in_if
// Input channel: frame header and data byte words.
// ----------------------------------------------------------------------------
interface cfaf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] frame_id;
  logic [7:0]  payload_length;
  logic [7:0]  fd_flags;
  logic [7:0]  raw_dlc;
  logic        is_fd;
  logic [7:0]  data_value;

  modport source (
    output valid, action, frame_id, payload_length, fd_flags, raw_dlc, is_fd, data_value,
    input  ready
  );
  modport sink (
    input  valid, action, frame_id, payload_length, fd_flags, raw_dlc, is_fd, data_value,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/core/cfaf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfaf_out_if
// Result channel: one ASCII character word with end of line mark.
// ----------------------------------------------------------------------------
interface cfaf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_line;

  modport source (
    output valid, character, end_of_line,
    input  ready
  );
  modport sink (
    input  valid, character, end_of_line,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/core/can_frame_ascii_formatter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_frame_ascii_formatter
// CAN / CAN FD frames to compact ASCII log text, one character per word.
//
//   channel  dir  handshake          word
//   in_ch    in   valid / ready      header or one data byte
//   out_ch   out  valid / ready      one character, end_of_line on last
//   cfg_*    in   cfg_wr_en          separator_enable bit
//
// a word is taken while the queue has room; the back sends one character per cycle unless out_ch stalls,
// up to 4 for a data byte (none for a stray byte, one if a DLC digit is pending), 4..12 for a header
// a two-job queue lets the front take new words while the back still sends
// reset clears frame state, the separator bit, the queue and the output
// ----------------------------------------------------------------------------
module can_frame_ascii_formatter #(
  parameter int unsigned FD_MAX_BYTES = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cfaf_in_if.sink    in_ch,
  cfaf_out_if.source out_ch,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data
);

  cfaf_pkg::job_t push_job;
  logic           push_valid;
  logic           push_ready;
  cfaf_pkg::job_t pop_job;
  logic           pop_valid;
  logic           pop_ready;

  cfaf_front #(
    .FD_MAX_BYTES (FD_MAX_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push_job    (push_job),
    .push_valid  (push_valid),
    .push_ready  (push_ready)
  );

  cfaf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_job    (pop_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  cfaf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_job   (pop_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

FILE: rtl/core/cfaf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfaf_front
// Accepts words, tracks frame state and builds the character job per word.
// ----------------------------------------------------------------------------
module cfaf_front #(
  parameter int unsigned FD_MAX_BYTES = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  cfaf_in_if.sink           in_ch,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_wr_data,
  output cfaf_pkg::job_t    push_job,
  output logic              push_valid,
  input  wire logic         push_ready
);

  localparam logic [7:0] FdMaxLen = 8'(FD_MAX_BYTES);

  logic                          sep_r;
  logic [cfaf_pkg::RemainW-1:0]  remain_r, remain_nxt;
  logic                          sfx_pend_r, sfx_pend_nxt;
  logic [3:0]                    sfx_digit_r, sfx_digit_nxt;

  cfaf_pkg::job_t                job;
  logic [cfaf_pkg::CountW-1:0]   n;
  logic                          accept;
  logic                          long_id;
  logic [31:0]                   id_val;
  logic                          raw_ok;
  logic [7:0]                    max_len;
  logic [7:0]                    len;
  logic [cfaf_pkg::RemainW-1:0]  remain_dec;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  always_comb begin
    job           = '0;
    n             = '0;
    remain_nxt    = remain_r;
    sfx_pend_nxt  = sfx_pend_r;
    sfx_digit_nxt = sfx_digit_r;
    long_id       = in_ch.frame_id[29] || in_ch.frame_id[31];
    raw_ok        = in_ch.raw_dlc inside {[cfaf_pkg::RawDlcLo:cfaf_pkg::RawDlcHi]};
    max_len       = in_ch.is_fd ? FdMaxLen : cfaf_pkg::ClassicMax;
    len           = (in_ch.payload_length > max_len) ? max_len : in_ch.payload_length;
    remain_dec    = remain_r - cfaf_pkg::RemainW'(1);
    if (in_ch.frame_id[29]) begin
      id_val = {2'b00, in_ch.frame_id[29:0]};
    end else if (in_ch.frame_id[31]) begin
      id_val = {3'b000, in_ch.frame_id[28:0]};
    end else begin
      id_val = {21'd0, in_ch.frame_id[10:0]};
    end

    if (in_ch.action == cfaf_pkg::ActHeader) begin
      remain_nxt    = '0;
      sfx_pend_nxt  = 1'b0;
      sfx_digit_nxt = '0;
      if (long_id) begin
        for (int k = 0; k < 8; k++) begin
          job.chars[k] = cfaf_pkg::hex_char(id_val[(7-k)*4 +: 4]);
        end
        n = 4'd8;
      end else begin
        for (int k = 0; k < 3; k++) begin
          job.chars[k] = cfaf_pkg::hex_char(id_val[(2-k)*4 +: 4]);
        end
        n = 4'd3;
      end
      job.chars[n] = cfaf_pkg::ChHash;
      n = n + 4'd1;
      if (!in_ch.is_fd && in_ch.frame_id[30]) begin
        job.chars[n] = cfaf_pkg::ChR;
        n = n + 4'd1;
        job.eol = 1'b1;
        if (in_ch.payload_length inside {[8'd1:cfaf_pkg::ClassicMax]}) begin
          job.chars[n] = cfaf_pkg::hex_char(in_ch.payload_length[3:0]);
          n = n + 4'd1;
          if (in_ch.payload_length == cfaf_pkg::ClassicMax && raw_ok) begin
            job.chars[n] = cfaf_pkg::ChUnder;
            n = n + 4'd1;
            if (long_id) begin
              job.eol       = 1'b0;
              sfx_pend_nxt  = 1'b1;
              sfx_digit_nxt = in_ch.raw_dlc[3:0];
            end else begin
              job.chars[n] = cfaf_pkg::hex_char(in_ch.raw_dlc[3:0]);
              n = n + 4'd1;
            end
          end
        end
      end else begin
        if (in_ch.is_fd) begin
          job.chars[n] = cfaf_pkg::ChHash;
          n = n + 4'd1;
          job.chars[n] = cfaf_pkg::hex_char(in_ch.fd_flags[3:0]);
          n = n + 4'd1;
          if (sep_r && len != 8'd0) begin
            job.chars[n] = cfaf_pkg::ChDot;
            n = n + 4'd1;
          end
        end
        if (len == 8'd0) begin
          job.eol = 1'b1;
        end else begin
          remain_nxt = len[cfaf_pkg::RemainW-1:0];
          if (!in_ch.is_fd && len == cfaf_pkg::ClassicMax && raw_ok) begin
            sfx_pend_nxt  = 1'b1;
            sfx_digit_nxt = in_ch.raw_dlc[3:0];
          end
        end
      end
    end else if (remain_r == '0) begin
      if (sfx_pend_r) begin
        job.chars[0]  = cfaf_pkg::hex_char(sfx_digit_r);
        n             = 4'd1;
        job.eol       = 1'b1;
        sfx_pend_nxt  = 1'b0;
        sfx_digit_nxt = '0;
      end
    end else begin
      job.chars[0] = cfaf_pkg::hex_char(in_ch.data_value[7:4]);
      job.chars[1] = cfaf_pkg::hex_char(in_ch.data_value[3:0]);
      n            = 4'd2;
      remain_nxt   = remain_dec;
      if (remain_dec != '0) begin
        if (sep_r) begin
          job.chars[2] = cfaf_pkg::ChDot;
          n            = 4'd3;
        end
      end else begin
        if (sfx_pend_r) begin
          job.chars[2]  = cfaf_pkg::ChUnder;
          job.chars[3]  = cfaf_pkg::hex_char(sfx_digit_r);
          n             = 4'd4;
          sfx_pend_nxt  = 1'b0;
          sfx_digit_nxt = '0;
        end
        job.eol = 1'b1;
      end
    end
    job.count = n;
  end

  assign push_job   = job;
  assign push_valid = accept && (n != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r       <= 1'b0;
      remain_r    <= '0;
      sfx_pend_r  <= 1'b0;
      sfx_digit_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        sep_r <= cfg_wr_data;
      end
      if (accept) begin
        remain_r    <= remain_nxt;
        sfx_pend_r  <= sfx_pend_nxt;
        sfx_digit_r <= sfx_digit_nxt;
      end
    end
  end

  a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (push_job.count != '0 &&
                    push_job.count <= cfaf_pkg::CountW'(cfaf_pkg::JobChars)))
    else $error("job character count out of range");

  a_remain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    remain_r <= cfaf_pkg::RemainW'(FD_MAX_BYTES))
    else $error("byte count beyond frame maximum");

endmodule
`default_nettype wire

FILE: rtl/core/cfaf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfaf_queue
// Short job queue between the front and the character sequencer.
// ----------------------------------------------------------------------------
module cfaf_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cfaf_pkg::job_t push_job,
  input  wire logic           push_valid,
  output logic                push_ready,
  output cfaf_pkg::job_t      pop_job,
  output logic                pop_valid,
  input  wire logic           pop_ready
);

  cfaf_pkg::job_t                 entry_r [cfaf_pkg::QueueDepth];
  logic [cfaf_pkg::QPtrW-1:0]     wr_ptr_r;
  logic [cfaf_pkg::QPtrW-1:0]     rd_ptr_r;
  logic [cfaf_pkg::QCountW-1:0]   count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = count_r != cfaf_pkg::QCountW'(cfaf_pkg::QueueDepth);
  assign pop_valid  = count_r != '0;
  assign pop_job    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + cfaf_pkg::QCountW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - cfaf_pkg::QCountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + cfaf_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + cfaf_pkg::QPtrW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cfaf_pkg::QCountW'(cfaf_pkg::QueueDepth))
    else $error("job queue overfilled");

endmodule
`default_nettype wire

FILE: rtl/core/cfaf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfaf_back
// Steps through the head job one character a cycle, when out_ch is not stalled, into the output register.
// ----------------------------------------------------------------------------
module cfaf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cfaf_pkg::job_t pop_job,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  cfaf_out_if.source          out_ch
);

  logic [cfaf_pkg::CountW-1:0] idx_r, idx_nxt;
  logic                        out_valid_r;
  logic [7:0]                  char_r;
  logic                        eol_r;
  logic                        load;
  logic                        last;

  assign load      = pop_valid && (!out_valid_r || out_ch.ready);
  assign last      = idx_r == (pop_job.count - cfaf_pkg::CountW'(1));
  assign pop_ready = load && last;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last ? '0 : idx_r + cfaf_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= pop_job.chars[idx_r];
      eol_r  <= last && pop_job.eol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.character   = char_r;
  assign out_ch.end_of_line = eol_r;

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid |-> (idx_r < pop_job.count))
    else $error("character index past end of job");

  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> (idx_r == '0))
    else $error("index not cleared after job");

endmodule
`default_nettype wire
